// ===== hdl/complex_rect_polar_convert_assert.svh =====
// Assertion macros for the rectangular/polar converter.
`ifndef COMPLEX_RECT_POLAR_CONVERT_ASSERT_SVH
`define COMPLEX_RECT_POLAR_CONVERT_ASSERT_SVH
`ifndef SYNTH
`define CRPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crpc assertion failed");
`define CRPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crpc assertion failed");
`else
`define CRPC_ASSERT_IMP(lbl, ante, cons)
`define CRPC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/crpc_pkg.sv =====
// Shared types, constants and arctangent table for the converter.
package crpc_pkg;

  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned TABLE_LEN     = 24;
  localparam int unsigned N_CELLS       = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES
                                                                      : TABLE_LEN;
  localparam int unsigned IDXW       = 5;
  localparam int unsigned XW         = 34;
  localparam int unsigned ZW         = 28;
  localparam int unsigned GW         = 31;
  localparam int unsigned PW         = XW + GW;
  localparam int unsigned GUARD      = 14;
  localparam int unsigned ANG_UP     = 11;
  localparam int unsigned PROD_SHIFT = 44;

  localparam int PI_Q13      = 25736;
  localparam int TWO_PI_Q13  = 51472;
  localparam int PI_Q24      = 52707179;
  localparam int HALF_PI_Q24 = 26353589;
  localparam int Q88_MAX     = 32767;
  localparam int Q88_MIN     = -32768;

  localparam logic signed [GW-1:0] INV_GAIN = 31'sd652032874;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_VECT,
    KIND_ROT
  } crpc_kind_e;

  typedef struct packed {
    logic               stored_form;
    logic               req_type;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
  } crpc_in_t;

  typedef struct packed {
    logic signed [15:0] out_first;
    logic signed [15:0] out_second;
    logic               saturated;
  } crpc_out_t;

  typedef struct packed {
    crpc_kind_e           kind;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } crpc_vec_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [ZW-1:0] crpc_atan(input logic [IDXW-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 28'sd13176795;
      5'd1:    v = 28'sd7778716;
      5'd2:    v = 28'sd4110060;
      5'd3:    v = 28'sd2086331;
      5'd4:    v = 28'sd1047214;
      5'd5:    v = 28'sd524117;
      5'd6:    v = 28'sd262123;
      5'd7:    v = 28'sd131069;
      5'd8:    v = 28'sd65536;
      5'd9:    v = 28'sd32768;
      5'd10:   v = 28'sd16384;
      5'd11:   v = 28'sd8192;
      5'd12:   v = 28'sd4096;
      5'd13:   v = 28'sd2048;
      5'd14:   v = 28'sd1024;
      5'd15:   v = 28'sd512;
      5'd16:   v = 28'sd256;
      5'd17:   v = 28'sd128;
      5'd18:   v = 28'sd64;
      5'd19:   v = 28'sd32;
      5'd20:   v = 28'sd16;
      5'd21:   v = 28'sd8;
      5'd22:   v = 28'sd4;
      5'd23:   v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/complex_rect_polar_convert.sv =====
// Pipeline: setup, one cell per stage, multiply, round/clamp into the output register.
// Throughput: one transfer per cycle unless the output stalls; every stage has its own
// valid bit and takes a new item whenever it is empty or its successor is moving, so
// bubbles collapse under stall.
// Reset clears only the stage valid bits; data registers are not reset.
module complex_rect_polar_convert (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crpc_pkg::crpc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crpc_pkg::crpc_out_t out_data_o
);
  import crpc_pkg::*;
  `include "complex_rect_polar_convert_assert.svh"

  logic [N_CELLS:0] chain_valid;
  logic [N_CELLS:0] chain_ready;
  crpc_vec_t        chain_data [N_CELLS+1];

  crpc_pre u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_data_o  (chain_data[0])
  );

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    crpc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_i     (IDXW'(k)),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_data_i   (chain_data[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_data_o  (chain_data[k+1])
    );
  end

  crpc_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[N_CELLS]),
    .in_ready_o  (chain_ready[N_CELLS]),
    .in_data_i   (chain_data[N_CELLS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // input only stalls when every stage holds an item
  `CRPC_ASSERT_IMP(a_full_when_blocked, !in_ready_o, (&chain_valid) && out_valid_o)
  // vectoring starts in the right half plane
  `CRPC_ASSERT_IMP(a_vect_right_half, chain_valid[0] && chain_data[0].kind == KIND_VECT,
                   !chain_data[0].x[XW-1])
  // rotation residual angle has converged after the last cell
  `CRPC_ASSERT_IMP(a_rot_converged,
                   chain_valid[N_CELLS] && chain_data[N_CELLS].kind == KIND_ROT,
                   (chain_data[N_CELLS].z <= (crpc_atan(IDXW'(N_CELLS-1)) <<< 1)) &&
                   (chain_data[N_CELLS].z >= -(crpc_atan(IDXW'(N_CELLS-1)) <<< 1)))

endmodule

// ===== hdl/crpc_pre.sv =====
// Input stage: picks the conversion, wraps the angle and sets up the CORDIC vector.
module crpc_pre (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  crpc_pkg::crpc_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output crpc_pkg::crpc_vec_t out_data_o
);
  import crpc_pkg::*;

  logic                 valid_q;
  crpc_vec_t            data_q, data_d;
  logic signed [15:0]   a, b;
  logic signed [XW-1:0] ax, bx;
  logic signed [16:0]   ang;
  logic signed [ZW-1:0] zr;

  assign a  = in_data_i.first_value;
  assign b  = in_data_i.second_value;
  assign ax = {{(XW-16-GUARD){a[15]}}, a, {GUARD{1'b0}}};
  assign bx = {{(XW-16-GUARD){b[15]}}, b, {GUARD{1'b0}}};

  always_comb begin
    ang = 17'(b);
    if (ang > 17'(PI_Q13)) begin
      ang = ang - 17'(TWO_PI_Q13);
    end
    if (ang < -17'(PI_Q13)) begin
      ang = ang + 17'(TWO_PI_Q13);
    end
    zr = {{(ZW-17-ANG_UP){ang[16]}}, ang, {ANG_UP{1'b0}}};
  end

  always_comb begin
    data_d.kind = KIND_PASS;
    data_d.x    = XW'(a);
    data_d.y    = XW'(b);
    data_d.z    = '0;
    if (in_data_i.stored_form != in_data_i.req_type) begin
      if (!in_data_i.stored_form) begin
        if (a == 16'sd0 && b == 16'sd0) begin
          data_d.x = '0;
          data_d.y = '0;
        end else begin
          data_d.kind = KIND_VECT;
          data_d.x    = ax;
          data_d.y    = bx;
          if (a < 16'sd0) begin
            data_d.x = -ax;
            data_d.y = -bx;
            data_d.z = (b >= 16'sd0) ? ZW'(PI_Q24) : -ZW'(PI_Q24);
          end
        end
      end else begin
        data_d.kind = KIND_ROT;
        data_d.x    = ax;
        data_d.y    = '0;
        data_d.z    = zr;
        if (zr > ZW'(HALF_PI_Q24)) begin
          data_d.z = zr - ZW'(PI_Q24);
          data_d.x = -ax;
        end else if (zr < -ZW'(HALF_PI_Q24)) begin
          data_d.z = zr + ZW'(PI_Q24);
          data_d.x = -ax;
        end
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/crpc_cell.sv =====
// One CORDIC micro-rotation cell with its own register stage.
module crpc_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [crpc_pkg::IDXW-1:0] stage_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  crpc_pkg::crpc_vec_t       in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output crpc_pkg::crpc_vec_t       out_data_o
);
  import crpc_pkg::*;

  logic                 valid_q;
  crpc_vec_t            data_q, data_d;
  logic signed [XW-1:0] xs, ys, dx, dy;
  logic signed [ZW-1:0] zs, da;

  assign xs = in_data_i.x;
  assign ys = in_data_i.y;
  assign zs = in_data_i.z;
  assign dx = ys >>> stage_i;
  assign dy = xs >>> stage_i;
  assign da = crpc_atan(stage_i);

  always_comb begin
    data_d = in_data_i;
    case (in_data_i.kind)
      KIND_VECT: begin
        if (ys > 0) begin
          data_d.x = xs + dx;
          data_d.y = ys - dy;
          data_d.z = zs + da;
        end else begin
          data_d.x = xs - dx;
          data_d.y = ys + dy;
          data_d.z = zs - da;
        end
      end
      KIND_ROT: begin
        if (zs >= 0) begin
          data_d.x = xs - dx;
          data_d.y = ys + dy;
          data_d.z = zs - da;
        end else begin
          data_d.x = xs + dx;
          data_d.y = ys - dy;
          data_d.z = zs + da;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/crpc_post.sv =====
// Output stages: gain correction multiply, then rounding, clamping and the output register.
module crpc_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crpc_pkg::crpc_vec_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crpc_pkg::crpc_out_t out_data_o
);
  import crpc_pkg::*;

  localparam int unsigned QW = PW - PROD_SHIFT + 1;
  localparam int unsigned AW = ZW - ANG_UP + 1;

  typedef struct packed {
    crpc_kind_e           kind;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [15:0]   raw_first;
    logic signed [15:0]   raw_second;
    logic signed [ZW-1:0] z;
  } crpc_prod_t;

  function automatic logic [16:0] sat_q88(input logic signed [QW-1:0] q);
    logic [16:0] r;
    if (q > QW'(Q88_MAX)) begin
      r = {1'b1, 16'sd32767};
    end else if (q < QW'(Q88_MIN)) begin
      r = {1'b1, -16'sd32768};
    end else begin
      r = {1'b0, q[15:0]};
    end
    return r;
  endfunction

  logic                 valid_a_q, ready_a;
  crpc_prod_t           prod_q, prod_d;
  logic                 valid_q;
  crpc_out_t            res_q, res_d;
  logic signed [XW-1:0] xs, ys;
  logic signed [PW:0]   rx, ry;
  logic signed [QW-1:0] qx, qy;
  logic signed [ZW:0]   za;
  logic signed [AW-1:0] ar;
  logic [16:0]          sx, sy;

  assign xs = in_data_i.x;
  assign ys = in_data_i.y;

  always_comb begin
    prod_d.kind       = in_data_i.kind;
    prod_d.px         = PW'(xs) * PW'(INV_GAIN);
    prod_d.py         = PW'(ys) * PW'(INV_GAIN);
    prod_d.raw_first  = xs[15:0];
    prod_d.raw_second = ys[15:0];
    prod_d.z          = in_data_i.z;
  end

  // half-up rounding of the products and the angle
  assign rx = (PW+1)'(prod_q.px) + ((PW+1)'(1) <<< (PROD_SHIFT-1));
  assign ry = (PW+1)'(prod_q.py) + ((PW+1)'(1) <<< (PROD_SHIFT-1));
  assign qx = rx[PW:PROD_SHIFT];
  assign qy = ry[PW:PROD_SHIFT];
  assign za = (ZW+1)'(prod_q.z) + (ZW+1)'(1 << (ANG_UP-1));
  assign ar = za[ZW:ANG_UP];
  assign sx = sat_q88(qx);
  assign sy = sat_q88(qy);

  always_comb begin
    res_d.out_first  = prod_q.raw_first;
    res_d.out_second = prod_q.raw_second;
    res_d.saturated  = 1'b0;
    case (prod_q.kind)
      KIND_VECT: begin
        res_d.out_first = sx[15:0];
        res_d.saturated = sx[16];
        if (ar > AW'(PI_Q13)) begin
          res_d.out_second = 16'(PI_Q13);
        end else if (ar < -AW'(PI_Q13)) begin
          res_d.out_second = -16'(PI_Q13);
        end else begin
          res_d.out_second = ar[15:0];
        end
      end
      KIND_ROT: begin
        res_d.out_first  = sx[15:0];
        res_d.out_second = sy[15:0];
        res_d.saturated  = sx[16] | sy[16];
      end
      default: ;
    endcase
  end

  assign ready_a     = !valid_q || out_ready_i;
  assign in_ready_o  = !valid_a_q || ready_a;
  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_a_q <= in_valid_i;
      end
      if (ready_a) begin
        valid_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q <= prod_d;
    end
    if (ready_a && valid_a_q) begin
      res_q <= res_d;
    end
  end

endmodule
